// File: rtl/jet_pkg.sv
// Package for the Julia set escape-time core.
// Holds the item and result structs, register indexes, fixed-point constants
// and the saturation helper. No dependencies.
package jet_pkg;

  localparam int FRAC_BITS = 28;
  localparam int MAX_SIDE  = 4096;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 16;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } jet_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_col;
    logic [IDX_W-1:0] out_row;
    logic [CNT_W-1:0] escape_count;
  } jet_out_t;

  typedef enum logic [2:0] {
    REG_CONST_RE   = 3'd0,
    REG_CONST_IM   = 3'd1,
    REG_RE_START   = 3'd2,
    REG_RE_STEP    = 3'd3,
    REG_IM_START   = 3'd4,
    REG_IM_STEP    = 3'd5,
    REG_RADIUS_SQ  = 3'd6,
    REG_MAX_ITER   = 3'd7
  } jet_reg_e;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = ~SAT_MAX;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_index(input logic [IDX_W-1:0] idx);
    logic [31:0] v;
    v = 32'(idx);
    if (v >= 32'(MAX_SIDE)) begin
      v = 32'(MAX_SIDE - 1);
    end
    return signed'(v);
  endfunction

endpackage

// File: rtl/jet_mul.sv
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
// Depends on nothing beyond the clock.
module jet_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: rtl/julia_escape_time_core.sv
// Top level of the Julia set escape-time core: sequencer, state and registers.
// Depends on jet_pkg and on the shared multiplier jet_mul.
// An accepted item first has its start point formed in S_MRE and S_MIM; each
// iteration then runs S_MRR, S_MII, S_MRI and S_UPD with three passes through the
// one shared multiplier, and the final magnitude test in S_MRI registers done_o.
// busy_o stays high until the result, so no new item is taken before then.
// The receiver cannot stall; reset clears control state and loads register defaults.
module julia_escape_time_core
  import jet_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  input  jet_in_t     item_i,
  output logic        busy_o,
  output logic        done_o,
  output jet_out_t    result_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MRE  = 7'b0000010,
    S_MIM  = 7'b0000100,
    S_MRR  = 7'b0001000,
    S_MII  = 7'b0010000,
    S_MRI  = 7'b0100000,
    S_UPD  = 7'b1000000
  } jet_state_e;

  jet_state_e         state_q, state_d;

  logic signed [30:0] const_re_q, const_im_q;
  logic signed [31:0] re_start_q, re_step_q, im_start_q, im_step_q;
  logic [30:0]        radius_q;
  logic [CNT_W-1:0]   max_iter_q;

  jet_in_t            item_q;
  logic signed [31:0] zr_q, zi_q;
  logic signed [63:0] rr_q, diff_q;
  logic [CNT_W-1:0]   count_q;
  logic               done_q;
  jet_out_t           result_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] start_sum;
  logic [63:0]        mag, limit;
  logic               stop;
  logic signed [31:0] nr, ni;
  logic               accept;

  jet_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign accept = start_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      const_re_q <= 31'sd536870912;
      const_im_q <= 31'sd0;
      re_start_q <= -32'sd536870912;
      re_step_q  <= 32'sd262272;
      im_start_q <= -32'sd536870912;
      im_step_q  <= 32'sd262272;
      radius_q   <= 31'd1073741824;
      max_iter_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (jet_reg_e'(cfg_idx_i))
        REG_CONST_RE:  const_re_q <= cfg_wdata_i[30:0];
        REG_CONST_IM:  const_im_q <= cfg_wdata_i[30:0];
        REG_RE_START:  re_start_q <= cfg_wdata_i;
        REG_RE_STEP:   re_step_q  <= cfg_wdata_i;
        REG_IM_START:  im_start_q <= cfg_wdata_i;
        REG_IM_STEP:   im_step_q  <= cfg_wdata_i;
        REG_RADIUS_SQ: radius_q   <= cfg_wdata_i[30:0];
        REG_MAX_ITER:  max_iter_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      S_MRE: begin
        mul_a = clamp_index(item_q.col);
        mul_b = re_step_q;
      end
      S_MIM: begin
        mul_a = clamp_index(item_q.row);
        mul_b = im_step_q;
      end
      S_MRR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      S_MII: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
    endcase
  end

  always_comb begin
    if (state_q == S_MIM) begin
      start_sum = 64'(re_start_q) + prod;
    end else begin
      start_sum = 64'(im_start_q) + prod;
    end
  end

  assign mag   = unsigned'(rr_q) + unsigned'(prod);
  assign limit = 64'(radius_q) << FRAC_BITS;
  assign stop  = !(count_q < max_iter_q) || !(mag < limit);
  assign nr    = sat32((diff_q >>> FRAC_BITS) + 64'(const_re_q));
  assign ni    = sat32((prod >>> (FRAC_BITS - 1)) + 64'(const_im_q));

  always_comb begin
    case (state_q)
      S_IDLE:  state_d = accept ? S_MRE : S_IDLE;
      S_MRE:   state_d = S_MIM;
      S_MIM:   state_d = S_MRR;
      S_MRR:   state_d = S_MII;
      S_MII:   state_d = S_MRI;
      S_MRI:   state_d = stop ? S_IDLE : S_UPD;
      S_UPD:   state_d = S_MRR;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_MRI) && stop;
      if (accept) begin
        count_q <= '0;
      end else if (state_q == S_UPD) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    case (state_q)
      S_MIM: zr_q <= sat32(start_sum);
      S_MRR: begin
        if (count_q == '0) begin
          zi_q <= sat32(start_sum);
        end
      end
      S_MII: rr_q <= prod;
      S_MRI: begin
        diff_q <= rr_q - prod;
        if (stop) begin
          result_q.out_col      <= item_q.col;
          result_q.out_row      <= item_q.row;
          result_q.escape_count <= count_q;
        end
      end
      S_UPD: begin
        zr_q <= nr;
        zi_q <= ni;
      end
      default: ;
    endcase
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  a_done_after_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_MRI))
    else $error("Result strobe without a preceding magnitude test.");

  a_start_enters_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_MRE))
    else $error("Accepted item did not start the sequence.");

  a_update_loops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (state_q == S_MRR && count_q == $past(count_q) + 1'b1))
    else $error("Iteration update did not loop back with the count advanced.");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("Result strobe while an item is still being worked on.");

endmodule

// File: tb/sv/julia_escape_time_core_tb.sv
// Self-checking testbench for julia_escape_time_core: pixels are driven through the
// start/busy handshake and each escape count is predicted and compared in a scoreboard.
// Depends on jet_pkg and the julia_escape_time_core RTL.
module julia_escape_time_core_tb
  import jet_pkg::*;
();

  class escape_scoreboard;
    jet_out_t          expected_q[$];
    int unsigned       errors;
    longint            c_re, c_im, re_org, re_inc, im_org, im_inc;
    longint unsigned   radius_sq;
    int unsigned       iter_limit;

    function new();
      errors     = 0;
      c_re       = 536870912;
      c_im       = 0;
      re_org     = -536870912;
      re_inc     = 262272;
      im_org     = -536870912;
      im_inc     = 262272;
      radius_sq  = 1073741824;
      iter_limit = 256;
    endfunction

    function void set_reg(jet_reg_e r, logic [31:0] v);
      case (r)
        REG_CONST_RE:  c_re = $signed(v[30:0]);
        REG_CONST_IM:  c_im = $signed(v[30:0]);
        REG_RE_START:  re_org = $signed(v);
        REG_RE_STEP:   re_inc = $signed(v);
        REG_IM_START:  im_org = $signed(v);
        REG_IM_STEP:   im_inc = $signed(v);
        REG_RADIUS_SQ: radius_sq = v[30:0];
        REG_MAX_ITER:  iter_limit = v[15:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void note_item(jet_in_t px);
      longint          zr, zi, rr, ii, ri, col_c, row_c;
      longint unsigned mag, bound;
      int unsigned     n;
      jet_out_t        res;
      col_c = (px.col >= MAX_SIDE) ? MAX_SIDE - 1 : px.col;
      row_c = (px.row >= MAX_SIDE) ? MAX_SIDE - 1 : px.row;
      zr    = clip32(re_org + col_c * re_inc);
      zi    = clip32(im_org + row_c * im_inc);
      bound = radius_sq << FRAC_BITS;
      n     = 0;
      while (n < iter_limit) begin
        rr  = zr * zr;
        ii  = zi * zi;
        ri  = zr * zi;
        mag = unsigned'(rr) + unsigned'(ii);
        if (mag >= bound) break;
        zr = clip32(((rr - ii) >>> FRAC_BITS) + c_re);
        zi = clip32((ri >>> (FRAC_BITS - 1)) + c_im);
        n++;
      end
      res.out_col      = px.col;
      res.out_row      = px.row;
      res.escape_count = CNT_W'(n);
      expected_q.push_back(res);
    endfunction

    function void check_result(jet_out_t got);
      jet_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_col %0d out_row %0d escape_count %0d",
               got.out_col, got.out_row, got.escape_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        errors++;
      end
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
        errors++;
      end
      if (got.escape_count !== want.escape_count) begin
        $error("escape_count: expected %0d, got %0d", want.escape_count, got.escape_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        start_i;
  jet_in_t     item_i;
  logic        busy_o;
  logic        done_o;
  jet_out_t    result_o;

  escape_scoreboard sb;

  julia_escape_time_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_pixel(input jet_in_t px, input int unsigned idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= px;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(px);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy_o);
    @(negedge clk_i);
  endtask

  task automatic load_config(input logic [31:0] cre, cim, re0, re_d, im0, im_d, rad, lim);
    logic [31:0] img [8];
    jet_reg_e    r;
    img = '{cre, cim, re0, re_d, im0, im_d, rad, lim};
    r = r.first();
    repeat (r.num()) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= r;
      cfg_wdata_i <= img[r];
      sb.set_reg(r, img[r]);
      @(negedge clk_i);
      r = r.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_const();
    case ($urandom_range(0, 3))
      0:       return -536870912;
      1:       return 536870912;
      default: return int'($urandom_range(0, 1073741824)) - 536870912;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(input int span);
    if ($urandom_range(0, 4) == 0) return $urandom;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic randomise_config();
    logic [31:0] rad, lim;
    case ($urandom_range(0, 3))
      0:       rad = $urandom;
      1:       rad = {1'($urandom), 31'($urandom_range(0, 1073741824))};
      default: rad = 32'h4000_0000;
    endcase
    lim = {16'($urandom), ($urandom_range(0, 9) == 0) ? 16'($urandom_range(49, 128))
                                                      : 16'($urandom_range(0, 48))};
    load_config({1'($urandom), 31'(rand_const())}, {1'($urandom), 31'(rand_const())},
                rand_coord(536870912), rand_coord(600000),
                rand_coord(536870912), rand_coord(600000), rad, lim);
  endtask

  initial begin
    jet_in_t px;
    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_CONST_RE;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    item_i      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_pixel(jet_in_t'{12'd0, 12'd0}, 0);
    send_pixel(jet_in_t'{12'd4095, 12'd4095}, 0);
    send_pixel(jet_in_t'{12'd2048, 12'd2048}, 0);
    send_pixel(jet_in_t'{12'd0, 12'd4095}, 0);
    send_pixel(jet_in_t'{12'd4095, 12'd0}, 0);

    // With c at zero, points near the origin stay bounded and run to the limit.
    drain_results();
    load_config(32'h0, 32'h0, 32'hE000_0000, 32'd262272, 32'hE000_0000, 32'd262272,
                32'h4000_0000, 32'd256);
    send_pixel(jet_in_t'{12'd2048, 12'd2048}, 0);
    send_pixel(jet_in_t'{12'd0, 12'd0}, 0);
    send_pixel(jet_in_t'{12'd2100, 12'd1900}, 0);

    drain_results();
    load_config(32'h2000_0000, 32'hE000_0000, 32'hE000_0000, 32'd262272, 32'hE000_0000,
                32'd262272, 32'h0, 32'hFFFF);
    send_pixel(jet_in_t'{12'd2048, 12'd2048}, 0);
    send_pixel(jet_in_t'{12'd4095, 12'd4095}, 0);

    drain_results();
    load_config(32'h0, 32'h0, 32'hE000_0000, 32'd262272, 32'hE000_0000, 32'd262272,
                32'h4000_0000, 32'h0);
    send_pixel(jet_in_t'{12'd2048, 12'd2048}, 0);
    send_pixel(jet_in_t'{12'd1, 12'd1}, 0);

    drain_results();
    load_config(32'hE000_0000, 32'h2000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF);
    send_pixel(jet_in_t'{12'd4095, 12'd4095}, 0);
    send_pixel(jet_in_t'{12'd0, 12'd0}, 0);
    send_pixel(jet_in_t'{12'd1, 12'd2048}, 0);

    // The widest threshold lets an iterate saturate on both axes before escaping.
    drain_results();
    load_config(32'hE000_0000, 32'h2000_0000, 32'h0, 32'd183550, 32'h0, 32'd183550,
                32'h7FFF_FFFF, 32'hFFFF);
    send_pixel(jet_in_t'{12'd0, 12'd4095}, 0);
    send_pixel(jet_in_t'{12'd2770, 12'd2770}, 0);
    send_pixel(jet_in_t'{12'd4095, 12'd0}, 0);
    send_pixel(jet_in_t'{12'd0, 12'd0}, 0);

    for (int ph = 0; ph < 9; ph++) begin
      drain_results();
      randomise_config();
      for (int k = 0; k < 95; k++) begin
        px.col = 12'($urandom);
        px.row = 12'($urandom);
        send_pixel(px, (ph < 3) ? 15 : ((ph < 6) ? 88 : 0));
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
